>>> rtl/sed_pkg.sv
package sed_pkg;

	// Character codes the decoder reacts to.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UX     = 8'h58;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LN     = 8'h6e;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LX     = 8'h78;

	// A numeric escape takes at most this many digits.
	localparam logic [1:0] MAX_DIGITS = 2'd3;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NEWLINE = 2'd1,
		ST_NUL     = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		status_t    status;
	} result_t;

	// One queue entry: the results caused by one input character.
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} cmd_t;

	// Hex digit value; bit 4 is set when the character is a hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_LA && c <= CH_LF_HEX) begin
				d = c - CH_LA + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else begin
				hex_digit = {1'b0, d[3:0]};
			end
		end
	endfunction

endpackage

>>> rtl/sed_char_if.sv
interface sed_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

>>> rtl/sed_byte_if.sv
interface sed_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_end;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_valid, output string_end,
		output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input string_end,
		input status, output ready);
endinterface

>>> rtl/sed_front.sv
module sed_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          append_terminator,
	sed_char_if.sink      char_stream,
	output logic          push_valid,
	output sed_pkg::cmd_t push_cmd,
	input  logic          push_ready
);
	import sed_pkg::*;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_OCTAL  = 4'b0100,
		MODE_HEX    = 4'b1000
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic [1:0] cnt_q, cnt_d;

	logic [7:0] c;
	logic       take;
	result_t    nr;
	logic       n_emit;
	logic       n_esc;
	logic       is_oct;
	logic [4:0] hv;
	logic [7:0] acc_oct;
	logic [7:0] acc_hex;
	logic [1:0] cnt_inc;
	logic       emit0;
	logic       emit1;
	result_t    r0;
	result_t    r1;

	assign c                 = char_stream.in_char;
	assign char_stream.ready = push_ready;
	assign take              = char_stream.valid && push_ready;

	assign is_oct  = (c >= CH_ZERO) && (c <= CH_SEVEN);
	assign hv      = hex_digit(c);
	assign acc_oct = {acc_q[4:0], 3'b000} + (c - CH_ZERO);
	assign acc_hex = {acc_q[3:0], 4'b0000} + {4'b0000, hv[3:0]};
	assign cnt_inc = cnt_q + 2'd1;

	// Handling of a character in normal mode.
	always_comb begin
		nr     = '0;
		n_emit = 1'b1;
		n_esc  = 1'b0;
		if (c == CH_QUOTE || c == CH_NUL) begin
			nr.byte_valid = append_terminator;
			nr.string_end = 1'b1;
			nr.status     = (c == CH_NUL) ? ST_NUL : ST_OK;
		end else if (c == CH_BSLASH) begin
			n_emit = 1'b0;
			n_esc  = 1'b1;
		end else if (c == CH_LF) begin
			nr.out_byte   = CH_LF;
			nr.byte_valid = 1'b1;
			nr.status     = ST_NEWLINE;
		end else begin
			nr.out_byte   = c;
			nr.byte_valid = 1'b1;
		end
	end

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		emit0  = 1'b0;
		emit1  = 1'b0;
		r0     = '0;
		r1     = '0;
		unique case (mode_q)
			MODE_NORMAL: begin
				r0    = nr;
				emit0 = n_emit;
				if (n_esc) begin
					mode_d = MODE_ESCAPE;
				end
			end
			MODE_ESCAPE: begin
				mode_d = MODE_NORMAL;
				if (is_oct) begin
					mode_d = MODE_OCTAL;
					acc_d  = c - CH_ZERO;
					cnt_d  = 2'd1;
				end else if (c == CH_LX || c == CH_UX) begin
					mode_d = MODE_HEX;
					acc_d  = '0;
					cnt_d  = '0;
				end else begin
					emit0         = 1'b1;
					r0.byte_valid = 1'b1;
					if (c == CH_LR) begin
						r0.out_byte = CH_CR;
					end else if (c == CH_LN) begin
						r0.out_byte = CH_LF;
					end else if (c == CH_BSLASH || c == CH_QUOTE) begin
						r0.out_byte = c;
					end else begin
						r0.byte_valid = 1'b0;
						r0.status     = ST_UNKNOWN;
					end
				end
			end
			MODE_OCTAL, MODE_HEX: begin
				if (((mode_q == MODE_OCTAL) ? is_oct : hv[4]) && cnt_q < MAX_DIGITS) begin
					acc_d = (mode_q == MODE_OCTAL) ? acc_oct : acc_hex;
					cnt_d = cnt_inc;
					if (cnt_inc >= MAX_DIGITS) begin
						mode_d        = MODE_NORMAL;
						cnt_d         = '0;
						emit0         = 1'b1;
						r0.out_byte   = acc_d;
						r0.byte_valid = 1'b1;
					end
				end else begin
					// Escape cut short: pending byte first, then the character
					// is handled as in normal mode.
					emit0         = 1'b1;
					r0.out_byte   = acc_q;
					r0.byte_valid = 1'b1;
					cnt_d         = '0;
					mode_d        = n_esc ? MODE_ESCAPE : MODE_NORMAL;
					r1            = nr;
					emit1         = n_emit;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
	end

	assign push_valid   = take && emit0;
	assign push_cmd.r0  = r0;
	assign push_cmd.r1  = r1;
	assign push_cmd.two = emit1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

>>> rtl/sed_queue.sv
module sed_queue #(
	parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  sed_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          pop_valid,
	output sed_pkg::cmd_t pop_cmd,
	input  logic          pop_ready
);
	import sed_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/sed_back.sv
module sed_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  sed_pkg::cmd_t pop_cmd,
	output logic          pop_ready,
	sed_byte_if.source    byte_stream
);
	import sed_pkg::*;

	logic    out_valid_q;
	result_t res_q;
	logic    second_q;
	logic    load;

	// The output register may take a new result when it is empty or drained.
	assign load      = !out_valid_q || byte_stream.ready;
	assign pop_ready = load && (!pop_cmd.two || second_q);

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			res_q <= second_q ? pop_cmd.r1 : pop_cmd.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				second_q <= pop_cmd.two && !second_q;
			end
		end
	end

	assign byte_stream.valid      = out_valid_q;
	assign byte_stream.out_byte   = res_q.out_byte;
	assign byte_stream.byte_valid = res_q.byte_valid;
	assign byte_stream.string_end = res_q.string_end;
	assign byte_stream.status     = res_q.status;

endmodule

>>> rtl/string_escape_decoder_top.sv
// String escape decoder.
// The char_stream channel carries one raw character of a quoted string body
// per transfer, starting just after the opening quote. The byte_stream
// channel carries the decoded results: a byte with its valid flag, a flag
// on the last result of each string, and a status code for raw newlines,
// strings ended by NUL and unknown escapes.
// The cfg_we and cfg_wdata port writes the append_terminator bit, which adds
// a zero byte as the last result of each string; write it only while idle.
// The results of a character are written into a queue entry and then into
// the output register before they appear on byte_stream. The front decoder
// takes one character per cycle while the queue has room; the output
// register sends one result per cycle while the receiver is ready, so a
// character that cuts a numeric escape short and yields two results holds
// the output for both of them. A four-entry queue between front and
// back absorbs those bursts and short receiver stalls.
// When the receiver stalls, the output holds its result, the queue fills,
// and char_stream.ready falls once the queue is full.
// Reset clears the decode mode, the escape accumulator and digit count, the
// queue and the output valid, and sets append_terminator to 0.
module string_escape_decoder_top #(
	parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	sed_char_if.sink   char_stream,
	sed_byte_if.source byte_stream
);
	import sed_pkg::*;

	logic append_q;
	logic push_valid;
	cmd_t push_cmd;
	logic push_ready;
	logic pop_valid;
	cmd_t pop_cmd;
	logic pop_ready;

	// Configuration register; only one bit is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_q <= 1'b0;
		end else if (cfg_we) begin
			append_q <= cfg_wdata;
		end
	end

	// Front: decodes characters and queues the results each one causes.
	sed_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.append_terminator (append_q),
		.char_stream       (char_stream),
		.push_valid        (push_valid),
		.push_cmd          (push_cmd),
		.push_ready        (push_ready)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop_ready  (pop_ready)
	);

	// Back: sends one or two results per queue entry through the output register.
	sed_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_cmd     (pop_cmd),
		.pop_ready   (pop_ready),
		.byte_stream (byte_stream)
	);

endmodule

>>> rtl/sed_checker.sv
module sed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       string_end,
	input logic [1:0] status
);
	import sed_pkg::*;

	// A stalled result stays on the port with its byte and status unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
	else $error("result changed while stalled");

	// A result without a data byte carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'h00)
	else $error("nonzero byte in result without data");

	// A result with NUL status always ends the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NUL |-> string_end)
	else $error("NUL status without string end");

	// The last result of a string is either empty or the zero terminator, never an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> out_byte == 8'h00 && status != ST_UNKNOWN
			&& status != ST_NEWLINE)
	else $error("bad string end result");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (byte_stream.valid),
	.out_ready  (byte_stream.ready),
	.out_byte   (byte_stream.out_byte),
	.byte_valid (byte_stream.byte_valid),
	.string_end (byte_stream.string_end),
	.status     (byte_stream.status)
);

>>> tb/string_escape_decoder_top_tb.sv
module string_escape_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sed_pkg::*;

	// Quiet cycles allowed after the last expected result before the block
	// counts as idle: the output register plus the four-entry queue, with margin.
	localparam int SETTLE_CYCLES = 10;
	// Cycles without any transfer on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Minimum characters per random phase; six phases give at least 1800 characters.
	localparam int PHASE_CHARS = 300;
	localparam int NUM_PHASES = 6;

	// Decode state of the escape parser, mirrored from the block's behavior.
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_OCT   = 2'd2,
		MODE_HEX   = 2'd3
	} esc_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sed_char_if char_bus ();
	sed_byte_if byte_bus ();

	string_escape_decoder_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.char_stream (char_bus),
		.byte_stream (byte_bus)
	);

	// Raw characters waiting to be offered on the character channel.
	logic [7:0] char_queue[$];
	// Decoded results still owed by the block, oldest first.
	result_t    owed_results[$];

	// Shadow of the decoder state and of the append_terminator register.
	esc_mode_t  esc_mode = MODE_PLAIN;
	logic [7:0] esc_acc = 8'h00;
	logic [1:0] esc_digits = 2'd0;
	logic       zero_term = 1'b0;

	int mismatch_count = 0;
	int result_index = 0;
	int quiet_cycles = 0;
	// Countdowns for the idle and stall draws on each side, and the stretches
	// in which a side runs without idling at all.
	int char_gap = 0;
	int byte_stall = 0;
	int char_calm = 0;
	int byte_calm = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH @%0t ns: %s", $time, what);
	endtask

	// Draws how many cycles a side holds off before its next transfer.
	// Now and then a stretch of a few dozen transfers runs with no hold-off.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic void owe_result(input logic [7:0] b, input logic v, input logic e,
		input status_t st);
		result_t r;
		r.out_byte = b;
		r.byte_valid = v;
		r.string_end = e;
		r.status = st;
		owed_results.push_back(r);
	endfunction

	// A character seen outside any escape: quote or NUL closes the string,
	// backslash opens an escape, a raw newline is kept but flagged.
	function automatic void plain_char(input logic [7:0] c);
		if (c == CH_QUOTE || c == CH_NUL) begin
			esc_mode = MODE_PLAIN;
			owe_result(8'h00, zero_term, 1'b1, (c == CH_NUL) ? ST_NUL : ST_OK);
		end else if (c == CH_BSLASH) begin
			esc_mode = MODE_ESC;
		end else if (c == CH_LF) begin
			owe_result(CH_LF, 1'b1, 1'b0, ST_NEWLINE);
		end else begin
			owe_result(c, 1'b1, 1'b0, ST_OK);
		end
	endfunction

	// Works out the results one accepted character causes, and advances the
	// shadow decoder state.
	function automatic void decode_char(input logic [7:0] c);
		logic       took;
		logic       cut;
		logic       hex_ok;
		logic [7:0] hex_val;
		took = 1'b0;
		cut = 1'b0;
		hex_ok = 1'b1;
		hex_val = 8'h00;
		case (esc_mode)
			MODE_ESC: begin
				esc_mode = MODE_PLAIN;
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					esc_mode = MODE_OCT;
					esc_acc = c - CH_ZERO;
					esc_digits = 2'd1;
				end else if (c == CH_LX || c == CH_UX) begin
					esc_mode = MODE_HEX;
					esc_acc = 8'h00;
					esc_digits = 2'd0;
				end else if (c == CH_LR) begin
					owe_result(CH_CR, 1'b1, 1'b0, ST_OK);
				end else if (c == CH_LN) begin
					owe_result(CH_LF, 1'b1, 1'b0, ST_OK);
				end else if (c == CH_BSLASH || c == CH_QUOTE) begin
					owe_result(c, 1'b1, 1'b0, ST_OK);
				end else begin
					owe_result(8'h00, 1'b0, 1'b0, ST_UNKNOWN);
				end
			end
			MODE_OCT: begin
				if (c >= CH_ZERO && c <= CH_SEVEN && esc_digits < MAX_DIGITS) begin
					esc_acc = {esc_acc[4:0], c[2:0]};
					took = 1'b1;
				end else begin
					cut = 1'b1;
				end
			end
			MODE_HEX: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					hex_val = c - CH_ZERO;
				else if (c >= CH_UA && c <= CH_UF)
					hex_val = c - CH_UA + 8'd10;
				else if (c >= CH_LA && c <= CH_LF_HEX)
					hex_val = c - CH_LA + 8'd10;
				else
					hex_ok = 1'b0;
				if (hex_ok && esc_digits < MAX_DIGITS) begin
					esc_acc = {esc_acc[3:0], hex_val[3:0]};
					took = 1'b1;
				end else begin
					cut = 1'b1;
				end
			end
			default: plain_char(c);
		endcase
		// A full numeric escape releases its byte with the last digit.
		if (took) begin
			esc_digits = esc_digits + 2'd1;
			if (esc_digits == MAX_DIGITS) begin
				owe_result(esc_acc, 1'b1, 1'b0, ST_OK);
				esc_mode = MODE_PLAIN;
				esc_digits = 2'd0;
			end
		end
		// A numeric escape cut short releases its byte, and the character that
		// cut it is then taken as an ordinary one, for up to two results.
		if (cut) begin
			owe_result(esc_acc, 1'b1, 1'b0, ST_OK);
			esc_mode = MODE_PLAIN;
			esc_digits = 2'd0;
			plain_char(c);
		end
	endfunction

	// Queues one string body with random content, mostly well-formed escapes,
	// closed by a quote or now and then by a raw NUL.
	function automatic void queue_string();
		int         pieces;
		int         kind;
		int         digits;
		int         v;
		logic [7:0] c;
		pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
		repeat (pieces) begin
			kind = $urandom_range(0, 99);
			if (kind < 38) begin
				// Printable character that means nothing special.
				do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
				char_queue.push_back(c);
			end else if (kind < 43) begin
				// Noise: any byte, which may end the string early.
				char_queue.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 48) begin
				char_queue.push_back(8'($urandom_range(128, 255)));
			end else if (kind < 51) begin
				char_queue.push_back(CH_LF);
			end else if (kind < 66) begin
				char_queue.push_back(CH_BSLASH);
				case ($urandom_range(0, 3))
					0: char_queue.push_back(CH_LR);
					1: char_queue.push_back(CH_LN);
					2: char_queue.push_back(CH_BSLASH);
					default: char_queue.push_back(CH_QUOTE);
				endcase
			end else if (kind < 79) begin
				char_queue.push_back(CH_BSLASH);
				digits = $urandom_range(1, 3);
				repeat (digits) char_queue.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
			end else if (kind < 93) begin
				char_queue.push_back(CH_BSLASH);
				char_queue.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
				digits = $urandom_range(0, 3);
				repeat (digits) begin
					v = $urandom_range(0, 15);
					if (v < 10)
						char_queue.push_back(8'(CH_ZERO + v));
					else
						char_queue.push_back(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10));
				end
			end else begin
				// Unknown escape: anything that does not start a known escape.
				char_queue.push_back(CH_BSLASH);
				do c = 8'($urandom_range(0, 255));
				while ((c >= CH_ZERO && c <= CH_SEVEN) || c == CH_LX || c == CH_UX ||
					c == CH_LR || c == CH_LN || c == CH_BSLASH || c == CH_QUOTE);
				char_queue.push_back(c);
			end
		end
		char_queue.push_back(($urandom_range(0, 9) == 0) ? CH_NUL : CH_QUOTE);
	endfunction

	// Blocks until every queued character has been sent and every owed result
	// has come back, then lets the block's pipeline drain.
	task automatic wait_idle();
		while (char_queue.size() != 0 || char_bus.valid || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes append_terminator; only called while the block is idle.
	task automatic write_term(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		zero_term = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Source side: offers queued characters one per transfer, holding each
	// until accepted and then idling for a drawn number of cycles.
	always @(posedge clk) begin : char_source
		logic       nv;
		logic [7:0] nc;
		nv = char_bus.valid;
		nc = char_bus.in_char;
		if (arst_n) begin
			if (char_bus.valid && char_bus.ready) begin
				nv = 1'b0;
				char_gap = draw_wait(char_calm);
			end
			if (!nv) begin
				if (char_gap > 0) begin
					char_gap--;
				end else if (char_queue.size() != 0) begin
					nc = char_queue.pop_front();
					nv = 1'b1;
				end
			end
		end
		char_bus.valid <= nv;
		char_bus.in_char <= nc;
	end

	// Sink side: after each result transfer, stalls for a drawn number of cycles.
	always @(posedge clk) begin : byte_sink
		logic nr;
		nr = byte_bus.ready;
		if (arst_n) begin
			if (byte_bus.valid && byte_bus.ready)
				byte_stall = draw_wait(byte_calm);
			if (byte_stall > 0) begin
				byte_stall--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
		end
		byte_bus.ready <= nr;
	end

	// Monitor: predicts on every character transfer, then checks every result
	// transfer against the oldest owed result. Predicting first keeps the
	// outcome independent of process order within the edge.
	always @(posedge clk) begin : observe
		result_t want;
		if (arst_n) begin
			if (char_bus.valid && char_bus.ready)
				decode_char(char_bus.in_char);
			if (byte_bus.valid && byte_bus.ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result %0d: unexpected, out_byte %02h",
						result_index, byte_bus.out_byte));
				end else begin
					want = owed_results.pop_front();
					if (byte_bus.out_byte !== want.out_byte)
						report_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
							result_index, byte_bus.out_byte, want.out_byte));
					if (byte_bus.byte_valid !== want.byte_valid)
						report_mismatch($sformatf("result %0d: byte_valid %b, expected %b",
							result_index, byte_bus.byte_valid, want.byte_valid));
					if (byte_bus.string_end !== want.string_end)
						report_mismatch($sformatf("result %0d: string_end %b, expected %b",
							result_index, byte_bus.string_end, want.string_end));
					if (byte_bus.status !== want.status)
						report_mismatch($sformatf("result %0d: status %0d, expected %0d",
							result_index, byte_bus.status, want.status));
				end
				result_index++;
			end
		end
		// Watchdog: a run of cycles with no transfer at all means a hang.
		if ((char_bus.valid && char_bus.ready) || (byte_bus.valid && byte_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic term_plan [NUM_PHASES];
		term_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.in_char = 8'h00;
		byte_bus.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with append_terminator at its reset value of 0.
		// Plain letter, top byte value, raw newline.
		char_queue.push_back("A");
		char_queue.push_back(8'hff);
		char_queue.push_back(CH_LF);
		// The four simple escapes.
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_LR);
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_LN);
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_BSLASH);
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_QUOTE);
		// Full octal escape that overflows the byte.
		char_queue.push_back(CH_BSLASH);
		char_queue.push_back(CH_SEVEN); char_queue.push_back(CH_SEVEN);
		char_queue.push_back(CH_SEVEN);
		// Octal escape cut short by a letter.
		char_queue.push_back(CH_BSLASH); char_queue.push_back("1"); char_queue.push_back("Z");
		// Hex escape with no digits, cut short by the closing quote.
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_LX);
		char_queue.push_back(CH_QUOTE);
		// NUL after a backslash is an unknown escape, not an end of string.
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_NUL);
		// Hex escape cut short by a raw NUL that ends the string.
		char_queue.push_back(CH_BSLASH); char_queue.push_back(CH_UX);
		char_queue.push_back("4"); char_queue.push_back(CH_NUL);
		wait_idle();

		// Random phases, each under its own append_terminator setting.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_term(term_plan[phase]);
			while (char_queue.size() < PHASE_CHARS)
				queue_string();
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
